// ===== design/lfrc_pkg.sv =====
package lfrc_pkg;

	// Width kept from the assembled frame length (8 to 16)
	localparam int LENGTH_BITS = 16;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_CAPACITY = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_MARKER    = 2'd1;

	localparam logic [15:0] CAPACITY_RESET = 16'd256;
	localparam logic [7:0]  MARKER_RESET   = 8'h23;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_GOOD    = 3'd1,
		EV_BADMARK = 3'd2,
		EV_TOOLONG = 3'd3,
		EV_BADSUM  = 3'd4
	} event_t;

	typedef struct packed {
		logic [15:0] buffer_capacity;
		logic [7:0]  frame_marker;
	} cfg_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		event_t      event_code;
	} result_t;

endpackage

// ===== design/lfrc_cfg_regs.sv =====
module lfrc_cfg_regs
	import lfrc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	output cfg_t                      cfg
);

	logic [15:0] capacity_q;
	logic [7:0]  marker_q;

	// Register file; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			marker_q   <= MARKER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUFFER_CAPACITY: capacity_q <= cfg_wdata[15:0];
				REG_FRAME_MARKER:    marker_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.buffer_capacity = capacity_q;
	assign cfg.frame_marker    = marker_q;

endmodule

// ===== design/lfrc_parser.sv =====
module lfrc_parser
	import lfrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output result_t    result
);

	typedef enum logic [1:0] {
		PH_MARKER = 2'd0,
		PH_LEN_LO = 2'd1,
		PH_LEN_HI = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [7:0]             len_lo_q;
	logic [LENGTH_BITS-1:0] length_q, length_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;
	logic [7:0]             sum_q, sum_d;
	logic [15:0]            len_full;
	logic [LENGTH_BITS-1:0] len_new;
	logic [16:0]            len_plus1;

	assign len_full  = {rx_byte, len_lo_q};
	assign len_new   = len_full[LENGTH_BITS-1:0];
	assign len_plus1 = 17'(len_new) + 17'd1;

	// Next state and result for the byte in the input stage
	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		count_d  = count_q;
		sum_d    = sum_q;
		result   = '{payload_valid: 1'b0, payload_byte: 8'd0,
			payload_index: 16'd0, event_code: EV_NONE};
		unique case (phase_q)
			PH_MARKER: begin
				if (rx_byte == cfg.frame_marker) begin
					count_d = '0;
					sum_d   = 8'd0;
					phase_d = PH_LEN_LO;
				end else begin
					result.event_code = EV_BADMARK;
				end
			end
			PH_LEN_LO: phase_d = PH_LEN_HI;
			PH_LEN_HI: begin
				length_d = len_new;
				if (len_plus1 <= {1'b0, cfg.buffer_capacity}) begin
					phase_d = PH_DATA;
				end else begin
					result.event_code = EV_TOOLONG;
					phase_d = PH_MARKER;
				end
			end
			PH_DATA: begin
				if (count_q < length_q) begin
					result.payload_valid = 1'b1;
					result.payload_byte  = rx_byte;
					result.payload_index = 16'(count_q);
					sum_d   = sum_q + rx_byte;
					count_d = count_q + 1'b1;
				end else begin
					result.event_code = (rx_byte == sum_q) ? EV_GOOD : EV_BADSUM;
					phase_d = PH_MARKER;
				end
			end
			default: phase_d = PH_MARKER;
		endcase
	end

	// Parse state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MARKER;
			len_lo_q <= 8'd0;
			length_q <= '0;
			count_q  <= '0;
			sum_q    <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			if (phase_q == PH_LEN_LO) begin
				len_lo_q <= rx_byte;
			end
		end
	end

endmodule

// ===== design/length_framed_rx_checksum_top.sv =====
// Length-framed byte receiver. Each accepted rx_byte item yields exactly one
// result item: a payload byte with its index, or an event (frame good, bad
// marker, too long, checksum mismatch), or nothing flagged. Frames are a
// marker byte, a 16-bit length low byte first, the payload and a mod-256 sum.
// One item per cycle is sustained while out_ready stays high. An accepted
// item is captured in the input register, runs through the parser logic and
// lands in the result register once the result stage can take it, and is
// presented from there. Configuration writes take effect at once and
// must be done while no item is in flight.
module length_framed_rx_checksum_top
	import lfrc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      payload_valid,
	output logic [7:0]                payload_byte,
	output logic [15:0]               payload_index,
	output logic [2:0]                event_code,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	cfg_t       cfg;
	result_t    result;
	result_t    result_s2;
	logic       valid_s1, valid_s2;
	logic [7:0] byte_s1;
	logic       s2_ready, s1_fire;

	lfrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lfrc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (s1_fire),
		.rx_byte (byte_s1),
		.result  (result)
	);

	assign s2_ready = !valid_s2 || out_ready;
	assign s1_fire  = valid_s1 && s2_ready;
	assign in_ready = !valid_s1 || s2_ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_valid = result_s2.payload_valid;
	assign payload_byte  = result_s2.payload_byte;
	assign payload_index = result_s2.payload_index;
	assign event_code    = result_s2.event_code;

endmodule

// ===== design/lfrc_checker.sv =====
module lfrc_checker
	import lfrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        payload_valid,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_index,
	input  logic [2:0]  event_code
);

	// A payload byte never carries an event
	a_payload_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> event_code == EV_NONE)
		else $error("payload item carries an event");

	// Non-payload results carry zero byte and index
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 16'd0)
		else $error("non-payload item has nonzero byte or index");

	// Event code stays within its defined codes
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= EV_BADSUM)
		else $error("undefined event code");

	// With no result pending the block always takes input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(payload_index) && $stable(event_code))
		else $error("stalled result changed");

endmodule

bind length_framed_rx_checksum_top lfrc_checker u_lfrc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.payload_valid (payload_valid),
	.payload_byte  (payload_byte),
	.payload_index (payload_index),
	.event_code    (event_code)
);
